[rtl/arpbcd_pkg.sv]
package arpbcd_pkg;

   // ARP operation code that gets processed
   localparam logic [15:0] OP_REPLY = 16'd2;

   // Multiplicative hash constant (golden ratio, 32 bits)
   localparam logic [31:0] HASH_MULT = 32'd2654435761;

   // Result status codes
   localparam logic [2:0] STATUS_IGNORED = 3'd0;
   localparam logic [2:0] STATUS_LEARNED = 3'd1;
   localparam logic [2:0] STATUS_SAME    = 3'd2;
   localparam logic [2:0] STATUS_CHANGED = 3'd3;
   localparam logic [2:0] STATUS_FULL    = 3'd4;

   // Input transaction
   typedef struct packed {
      logic [15:0] opcode;
      logic [31:0] src_ip;
      logic [47:0] src_mac;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] previous_mac;
   } rsp_type;

   // Table access controls from the sequencer
   typedef struct packed {
      logic rd_en;
      logic valid_we;
      logic valid_wdata;
      logic entry_we;
   } tbl_ctrl_type;

   // Sequencer states
   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_HASH,
      FSM_PROBE
   } state_type;

endpackage

[rtl/arp_binding_change_detector_unit.sv]
// ARP binding change detector. Each accepted transaction (start high while busy is low)
// carries one ARP header and yields exactly one result, shown on rsp_item for a single
// cycle with rsp_strobe high; the receiver cannot stall, so results must be taken when
// strobed. A non-reply opcode reports "ignored" in the cycle after acceptance and busy
// stays low. A reply is hashed into a linear-probing table of CACHE_ENTRIES slots (a
// power of two); the table memory gives one slot read per cycle, and a reply visits
// 1 to CACHE_ENTRIES slots, with busy high until its result is strobed. After reset the
// block sweeps every valid mark with busy high before it takes the first transaction.
module arp_binding_change_detector_unit #(
   parameter int CACHE_ENTRIES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  arpbcd_pkg::req_type req_item,
   output logic                rsp_strobe,
   output arpbcd_pkg::rsp_type rsp_item
);

   localparam int IDX_W = $clog2(CACHE_ENTRIES);

   arpbcd_pkg::state_type    state_ff, state_in;
   logic [IDX_W-1:0]         clr_ff, clr_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic [IDX_W-1:0]         cnt_ff, cnt_in;
   logic [31:0]              ip_ff, ip_in;
   logic [47:0]              mac_ff, mac_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   arpbcd_pkg::rsp_type      rsp_ff, rsp_in;

   arpbcd_pkg::tbl_ctrl_type tbl_ctrl;
   logic [IDX_W-1:0]         rd_addr;
   logic [IDX_W-1:0]         wr_addr;
   logic                     hash_en;
   logic [IDX_W-1:0]         hash_slot;
   logic                     rd_valid;
   logic [31:0]              rd_ip;
   logic [47:0]              rd_mac;

   arpbcd_hash #(
      .CACHE_ENTRIES(CACHE_ENTRIES)
   ) u_hash (
      .clock(clock),
      .en   (hash_en),
      .ip   (req_item.src_ip),
      .slot (hash_slot)
   );

   arpbcd_table #(
      .CACHE_ENTRIES(CACHE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .ctrl    (tbl_ctrl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_ip   (ip_ff),
      .wr_mac  (mac_ff),
      .rd_valid(rd_valid),
      .rd_ip   (rd_ip),
      .rd_mac  (rd_mac)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= arpbcd_pkg::FSM_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      cnt_ff  <= cnt_in;
      ip_ff   <= ip_in;
      mac_ff  <= mac_in;
      rsp_ff  <= rsp_in;
   end

   // Sequencer: clear sweep, hash, then one probe per cycle
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      ip_in         = ip_ff;
      mac_in        = mac_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      tbl_ctrl      = '0;
      rd_addr       = slot_ff + 1'b1;
      wr_addr       = slot_ff;
      hash_en       = 1'b0;

      unique case (state_ff)
         arpbcd_pkg::FSM_CLEAR: begin
            tbl_ctrl.valid_we    = 1'b1;
            tbl_ctrl.valid_wdata = 1'b0;
            wr_addr              = clr_ff;
            clr_in               = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = arpbcd_pkg::FSM_IDLE;
            end
         end

         arpbcd_pkg::FSM_IDLE: begin
            if (start) begin
               ip_in   = req_item.src_ip;
               mac_in  = req_item.src_mac;
               hash_en = 1'b1;
               if (req_item.opcode == arpbcd_pkg::OP_REPLY) begin
                  state_in = arpbcd_pkg::FSM_HASH;
               end else begin
                  rsp_strobe_in       = 1'b1;
                  rsp_in.status       = arpbcd_pkg::STATUS_IGNORED;
                  rsp_in.previous_mac = '0;
               end
            end
         end

         arpbcd_pkg::FSM_HASH: begin
            tbl_ctrl.rd_en = 1'b1;
            rd_addr        = hash_slot;
            slot_in        = hash_slot;
            cnt_in         = '0;
            state_in       = arpbcd_pkg::FSM_PROBE;
         end

         arpbcd_pkg::FSM_PROBE: begin
            if (!rd_valid) begin
               // free slot learns the binding
               tbl_ctrl.valid_we    = 1'b1;
               tbl_ctrl.valid_wdata = 1'b1;
               tbl_ctrl.entry_we    = 1'b1;
               rsp_strobe_in        = 1'b1;
               rsp_in.status        = arpbcd_pkg::STATUS_LEARNED;
               rsp_in.previous_mac  = '0;
               state_in             = arpbcd_pkg::FSM_IDLE;
            end else if (rd_ip == ip_ff) begin
               rsp_strobe_in = 1'b1;
               state_in      = arpbcd_pkg::FSM_IDLE;
               if (rd_mac != mac_ff) begin
                  // binding moved: report old MAC, store new one
                  tbl_ctrl.entry_we   = 1'b1;
                  rsp_in.status       = arpbcd_pkg::STATUS_CHANGED;
                  rsp_in.previous_mac = rd_mac;
               end else begin
                  rsp_in.status       = arpbcd_pkg::STATUS_SAME;
                  rsp_in.previous_mac = '0;
               end
            end else if (cnt_ff == '1) begin
               // every slot visited
               rsp_strobe_in       = 1'b1;
               rsp_in.status       = arpbcd_pkg::STATUS_FULL;
               rsp_in.previous_mac = '0;
               state_in            = arpbcd_pkg::FSM_IDLE;
            end else begin
               // next slot, wrapping at the table end
               tbl_ctrl.rd_en = 1'b1;
               slot_in        = slot_ff + 1'b1;
               cnt_in         = cnt_ff + 1'b1;
            end
         end

         default: begin
            state_in = arpbcd_pkg::FSM_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != arpbcd_pkg::FSM_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

[rtl/arpbcd_hash.sv]
module arpbcd_hash #(
   parameter int CACHE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic [31:0]                      ip,
   output logic [$clog2(CACHE_ENTRIES)-1:0] slot
);

   localparam int IDX_W = $clog2(CACHE_ENTRIES);

   logic [31:0]      prod;
   logic [IDX_W-1:0] slot_ff;

   // Low 32 bits of the product; the table index is its low bits
   assign prod = ip * arpbcd_pkg::HASH_MULT;

   always_ff @(posedge clock) begin
      if (en) begin
         slot_ff <= prod[IDX_W-1:0];
      end
   end

   assign slot = slot_ff;

endmodule

[rtl/arpbcd_table.sv]
module arpbcd_table #(
   parameter int CACHE_ENTRIES = 256
) (
   input  logic                             clock,
   input  arpbcd_pkg::tbl_ctrl_type         ctrl,
   input  logic [$clog2(CACHE_ENTRIES)-1:0] rd_addr,
   input  logic [$clog2(CACHE_ENTRIES)-1:0] wr_addr,
   input  logic [31:0]                      wr_ip,
   input  logic [47:0]                      wr_mac,
   output logic                             rd_valid,
   output logic [31:0]                      rd_ip,
   output logic [47:0]                      rd_mac
);

   // Valid marks, cleared by the sweep after reset
   logic        valid_mem [CACHE_ENTRIES];
   // IP/MAC bindings, meaningful only where the valid mark is set
   logic [79:0] entry_mem [CACHE_ENTRIES];

   logic        rd_valid_ff;
   logic [79:0] rd_entry_ff;

   // Valid memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctrl.valid_we) begin
         valid_mem[wr_addr] <= ctrl.valid_wdata;
      end
      if (ctrl.rd_en) begin
         rd_valid_ff <= valid_mem[rd_addr];
      end
   end

   // Entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctrl.entry_we) begin
         entry_mem[wr_addr] <= {wr_ip, wr_mac};
      end
      if (ctrl.rd_en) begin
         rd_entry_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_ip    = rd_entry_ff[79:48];
   assign rd_mac   = rd_entry_ff[47:0];

endmodule

[rtl/arpbcd_checker.sv]
module arpbcd_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input arpbcd_pkg::req_type req_item,
   input logic                rsp_strobe,
   input arpbcd_pkg::rsp_type rsp_item
);

   // A non-reply transaction is answered "ignored" in the next cycle
   a_ignore_next: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.opcode != arpbcd_pkg::OP_REPLY)
      |=> (rsp_strobe && rsp_item.status == arpbcd_pkg::STATUS_IGNORED))
      else $error("non-reply transaction not answered as ignored");

   // A reply keeps the block busy while the table is probed
   a_reply_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.opcode == arpbcd_pkg::OP_REPLY) |=> (busy && !rsp_strobe))
      else $error("reply transaction did not hold busy");

   // Old MAC is reported only with the change alert
   a_prev_mac_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != arpbcd_pkg::STATUS_CHANGED)
      |-> (rsp_item.previous_mac == 48'd0))
      else $error("previous_mac nonzero without change alert");

   // A table result follows a probe cycle
   a_table_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != arpbcd_pkg::STATUS_IGNORED) |-> $past(busy))
      else $error("table result without a preceding probe");

endmodule

bind arp_binding_change_detector_unit arpbcd_checker u_arpbcd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_strobe(rsp_strobe),
   .rsp_item  (rsp_item)
);
